// ===== sv/crgl_pkg.sv =====
// Shared types and constants of the charcode run glyph lookup block.
package crgl_pkg;

    localparam int DEF_MAX_RUNS = 256;

    localparam int SLOT_W   = 8;
    localparam int CODE_W   = 16;
    localparam int GLYPH_W  = 16;
    localparam int RCOUNT_W = 9;
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [GLYPH_W-1:0] NOT_FOUND_INDEX = 16'hFFFF;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_RUN_COUNT   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GLYPH_COUNT = 1'b1;

    // One table entry: first code of the run and glyph of that code.
    typedef struct packed {
        logic [CODE_W-1:0]  start;
        logic [GLYPH_W-1:0] glyph;
    } t_entry;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic wr;        // store a run entry from the input word
        logic start;     // latch the code and open the search window
        logic step;      // compare one probe and narrow the window
        logic fin0;      // form the offset index from the lower run
        logic fin1;      // check the index against its bound
        logic load_out;  // move the result into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;       // no valid runs, every lookup misses
        logic hit;         // probe start code equals the looked-up code
        logic search_end;  // window closes after this probe
        logic lo_zero;     // code lies below the first run
        logic out_free;    // output register can take a result
    } t_status;

endpackage

// ===== sv/charcode_run_glyph_lookup_unit.sv =====
// Top level of the charcode run glyph lookup block: controller plus datapath.
//
// The slave stream carries two kinds of word, told apart by s_axis_tuser.
// A write word stores one run (first code and first glyph) at a table slot
// and produces no result. A lookup word binary-searches the first run_count
// slots (at most the table depth) for the character code and produces one result
// word on the master stream: the found flag in m_axis_tuser and the glyph
// index in m_axis_tdata (0xFFFF when the code has no glyph).
// The configuration channel writes run_count (index 0) and glyph_count (index 1);
// it is always ready, and the user must write it only while the block is idle.
// The block itself does not enforce this. A lookup that hits a run start, misses
// below the first run or finds no valid runs loads its result after its probes,
// once the output register is free; the number of probes is at most
// floor(log2(n)) + 1 for n valid runs (9 for a full table, 0 when empty). Each
// probe is one read of the single read port of the run table memory, so that port
// sets the rate. Codes that fall between run starts pass through the states FIN0
// and FIN1 to read the lower run and the bound of the next run. The next word is
// taken only once the result is loaded. If the receiver stalls, write words are
// still taken, but the next lookup holds its result and takes no word until the
// output register frees. Reset clears both counts and the output valid flag.
module charcode_run_glyph_lookup_unit #(
    parameter int MAX_RUNS = crgl_pkg::DEF_MAX_RUNS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Input words.
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata, low bit up: run_slot[7:0], run_first_code[23:8],
    // run_first_glyph[39:24], char_code[55:40].
    input  logic [crgl_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // tuser: operation (0 write, 1 lookup).
    input  logic [0:0]                         s_axis_tuser,
    // Result words.
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // tdata: glyph_index[15:0].
    output logic [crgl_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // tuser: found.
    output logic [0:0]                         m_axis_tuser,
    // Configuration writes.
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [crgl_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [crgl_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    crgl_pkg::t_cmd    w_cmd;
    crgl_pkg::t_status w_status;
    logic              w_out_found;

    // Configuration registers never stall.
    assign o_cfg_ready = 1'b1;

    crgl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_op    (s_axis_tuser[0]),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    crgl_dp #(
        .MAX_RUNS (MAX_RUNS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_slot        (s_axis_tdata[7:0]),
        .i_first_code  (s_axis_tdata[23:8]),
        .i_first_glyph (s_axis_tdata[39:24]),
        .i_char_code   (s_axis_tdata[55:40]),
        .i_cfg_we      (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_out_found   (w_out_found),
        .o_out_glyph   (m_axis_tdata)
    );

    assign m_axis_tuser[0] = w_out_found;

endmodule

// ===== sv/crgl_ctrl.sv =====
// Controller state machine that sequences writes and binary-search lookups.
module crgl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_op,
    output logic              o_in_ready,
    input  crgl_pkg::t_status i_status,
    output crgl_pkg::t_cmd    o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SEARCH = 5'b00010,
        S_FIN0   = 5'b00100,
        S_FIN1   = 5'b01000,
        S_DONE   = 5'b10000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_op == crgl_pkg::OP_WRITE) begin
                        o_cmd.wr = 1'b1;
                    end else begin
                        o_cmd.start = 1'b1;
                        n_state = i_status.empty ? S_DONE : S_SEARCH;
                    end
                end
            end
            S_SEARCH: begin
                o_cmd.step = 1'b1;
                if (i_status.hit) begin
                    n_state = S_DONE;
                end else if (i_status.search_end) begin
                    n_state = i_status.lo_zero ? S_DONE : S_FIN0;
                end
            end
            S_FIN0: begin
                o_cmd.fin0 = 1'b1;
                n_state = S_FIN1;
            end
            S_FIN1: begin
                o_cmd.fin1 = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/crgl_dp.sv =====
// Datapath: run table memory, search window, bound check and output register.
module crgl_dp #(
    parameter int MAX_RUNS = crgl_pkg::DEF_MAX_RUNS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  crgl_pkg::t_cmd                      i_cmd,
    output crgl_pkg::t_status                   o_status,
    input  logic [crgl_pkg::SLOT_W-1:0]         i_slot,
    input  logic [crgl_pkg::CODE_W-1:0]         i_first_code,
    input  logic [crgl_pkg::GLYPH_W-1:0]        i_first_glyph,
    input  logic [crgl_pkg::CODE_W-1:0]         i_char_code,
    input  logic                                i_cfg_we,
    input  logic [crgl_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [crgl_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_out_found,
    output logic [crgl_pkg::GLYPH_W-1:0]        o_out_glyph
);

    localparam int AW = $clog2(MAX_RUNS);
    localparam int NW = $clog2(MAX_RUNS + 1);
    localparam int GW = crgl_pkg::GLYPH_W;

    crgl_pkg::t_entry r_mem [MAX_RUNS];
    crgl_pkg::t_entry r_rdata;

    logic [crgl_pkg::RCOUNT_W-1:0] r_run_count;
    logic [GW-1:0]                 r_glyph_count;
    logic [crgl_pkg::CODE_W-1:0]   r_code;
    logic [NW-1:0]                 r_lo, r_hix;
    logic [AW-1:0]                 r_mid;
    logic [GW:0]                   r_idx;
    logic                          r_res_found;
    logic [GW-1:0]                 r_res_glyph;
    logic                          r_out_valid;
    logic                          r_out_found;
    logic [GW-1:0]                 r_out_glyph;

    logic [NW-1:0] w_n;
    logic [NW:0]   w_sum0, w_sum1;
    logic [NW-1:0] w_mid_ext, w_lo_n, w_hix_n;
    logic          w_lt, w_gt, w_hit, w_end;
    logic [AW-1:0] w_raddr;
    logic [GW-1:0] w_bound;
    logic          w_slot_ok;

    // Effective run count, limited to the table depth.
    always_comb begin
        if (32'(r_run_count) > MAX_RUNS) begin
            w_n = NW'(MAX_RUNS);
        end else begin
            w_n = NW'(r_run_count);
        end
    end

    // Probe compare and window update; the next midpoint follows from it.
    assign w_hit     = (r_rdata.start == r_code);
    assign w_lt      = (r_rdata.start < r_code);
    assign w_gt      = (r_rdata.start > r_code);
    assign w_mid_ext = NW'(r_mid);
    assign w_lo_n    = w_lt ? (w_mid_ext + NW'(1)) : r_lo;
    assign w_hix_n   = w_gt ? w_mid_ext : r_hix;
    assign w_end     = (w_lo_n >= w_hix_n);
    assign w_sum0    = {1'b0, w_n} - (NW+1)'(1);
    assign w_sum1    = {1'b0, w_lo_n} + {1'b0, w_hix_n} - (NW+1)'(1);
    assign w_slot_ok = (32'(i_slot) < MAX_RUNS);
    assign w_bound   = (r_lo < w_n) ? r_rdata.glyph : r_glyph_count;

    always_comb begin
        w_raddr = r_mid;
        if (i_cmd.start) begin
            w_raddr = AW'(w_sum0[NW:1]);
        end else if (i_cmd.step) begin
            w_raddr = w_end ? AW'(w_lo_n - NW'(1)) : AW'(w_sum1[NW:1]);
        end else if (i_cmd.fin0) begin
            w_raddr = AW'(r_lo);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr && w_slot_ok) begin
            r_mem[AW'(i_slot)] <= '{start: i_first_code, glyph: i_first_glyph};
        end
        r_rdata <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_count   <= '0;
            r_glyph_count <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                crgl_pkg::CFG_RUN_COUNT:
                    r_run_count <= i_cfg_data[crgl_pkg::RCOUNT_W-1:0];
                crgl_pkg::CFG_GLYPH_COUNT:
                    r_glyph_count <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_code      <= i_char_code;
            r_lo        <= '0;
            r_hix       <= w_n;
            r_mid       <= AW'(w_sum0[NW:1]);
            r_res_found <= 1'b0;
            r_res_glyph <= crgl_pkg::NOT_FOUND_INDEX;
        end else if (i_cmd.step) begin
            r_lo  <= w_lo_n;
            r_hix <= w_hix_n;
            r_mid <= AW'(w_sum1[NW:1]);
            if (w_hit) begin
                r_res_found <= 1'b1;
                r_res_glyph <= r_rdata.glyph;
            end
        end else if (i_cmd.fin0) begin
            // The lower run always starts below the code, so the offset is positive.
            r_idx <= {1'b0, r_rdata.glyph} + {1'b0, r_code - r_rdata.start};
        end else if (i_cmd.fin1) begin
            if (r_idx < {1'b0, w_bound}) begin
                r_res_found <= 1'b1;
                r_res_glyph <= r_idx[GW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_found <= r_res_found;
            r_out_glyph <= r_res_glyph;
        end
    end

    assign o_status.empty      = (w_n == '0);
    assign o_status.hit        = w_hit;
    assign o_status.search_end = w_end;
    assign o_status.lo_zero    = (w_lo_n == '0);
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_found = r_out_found;
    assign o_out_glyph = r_out_glyph;

endmodule
